// ===== design/fre_pkg.sv =====
// Shared types and constants for the fisheye ray direction pipeline.
package fre_pkg;

  // Register map of the write port
  typedef enum logic [2:0] {
    REG_RESOLUTION  = 3'd0,
    REG_COS_HEADING = 3'd1,
    REG_SIN_HEADING = 3'd2,
    REG_COS_PITCH   = 3'd3,
    REG_SIN_PITCH   = 3'd4
  } reg_index_t;

  localparam int RES_W  = 13;
  localparam int PIX_W  = 12;
  localparam int Q14_W  = 16;
  localparam int Q14_ONE = 16384;

  // Sideband that travels with an item through the long arithmetic stages
  typedef struct packed {
    logic valid;
    logic in_disc;
    logic neg_x;
    logic neg_y;
  } side_t;

  // Clamp a wide Q1.14 value to [-1, +1]
  function automatic logic signed [Q14_W-1:0] q14_sat(input logic signed [21:0] v);
    logic signed [Q14_W-1:0] r;
    if (v > 22'sd16384) r = 16'sd16384;
    else if (v < -22'sd16384) r = -16'sd16384;
    else r = v[Q14_W-1:0];
    return r;
  endfunction

endpackage

// ===== design/fisheye_ray_direction.sv =====
// Top level: orthographic fisheye ray direction pipeline.
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+--------------------------
//  pixel in | pixel_x, pixel_y                      | start (busy always low)
//  ray out  | dir_x, dir_y, dir_z, inside_res       | done, one-cycle strobe
//  config   | wr_index, wr_data                     | wr_en, no wait
//
// One pixel enters every cycle.
// Latency is set by the z path: 31 divider stages for d/res^2 and 16 square
// root stages, plus four front stages and four rotation stages.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module fisheye_ray_direction
  import fre_pkg::*;
#(
  parameter int MAX_RESOLUTION = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [PIX_W-1:0]         pixel_x,
  input  logic [PIX_W-1:0]         pixel_y,
  output logic                     done,
  output logic signed [Q14_W-1:0]  dir_x,
  output logic signed [Q14_W-1:0]  dir_y,
  output logic signed [Q14_W-1:0]  dir_z,
  output logic                     inside_res,
  input  logic                     wr_en,
  input  logic [2:0]               wr_index,
  input  logic [Q14_W-1:0]         wr_data
);

  localparam int SQ_W   = 2 * RES_W;
  localparam int XD_LAT = 15;
  localparam int ZD_LAT = 47;
  localparam int LAT    = 55;

  // Configuration registers
  logic [RES_W-1:0]         res;
  logic [SQ_W-1:0]          res_sq;
  logic signed [Q14_W-1:0]  cos_h, sin_h, cos_p, sin_p;
  logic [RES_W-1:0]         wr_res;

  assign busy = 1'b0;

  // Clamp the written resolution to the supported range
  always_comb begin
    wr_res = wr_data[RES_W-1:0];
    priority if (wr_res == '0) wr_res = RES_W'(1);
    else if (32'(wr_res) > MAX_RESOLUTION) wr_res = RES_W'(MAX_RESOLUTION);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res    <= RES_W'(100);
      res_sq <= SQ_W'(10000);
      cos_h  <= 16'sd16384;
      sin_h  <= '0;
      cos_p  <= 16'sd16384;
      sin_p  <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_RESOLUTION: begin
          res    <= wr_res;
          res_sq <= SQ_W'(wr_res) * SQ_W'(wr_res);
        end
        REG_COS_HEADING: cos_h <= $signed(wr_data);
        REG_SIN_HEADING: sin_h <= $signed(wr_data);
        REG_COS_PITCH:   cos_p <= $signed(wr_data);
        REG_SIN_PITCH:   sin_p <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  // Front stages: capture, centre offset, squares, disc test
  logic                v1, v2, v3, v4;
  logic [PIX_W-1:0]    px1, py1;
  logic signed [14:0]  nx2, ny2;
  logic [13:0]         mx3, my3;
  logic                negx3, negy3;
  logic [27:0]         sqx3, sqy3;
  logic [28:0]         r2;
  logic                in4_c;
  logic [13:0]         mx_c, my_c;
  logic                in4, negx4, negy4;
  side_t               side4;
  logic [28:0]         numx4, numy4;
  logic [SQ_W-1:0]     dz4;

  always_comb begin
    mx_c  = nx2[14] ? 14'(-nx2) : 14'(nx2);
    my_c  = ny2[14] ? 14'(-ny2) : 14'(ny2);
    r2    = 29'(sqx3) + 29'(sqy3);
    in4_c = r2 <= 29'(res_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    px1   <= pixel_x;
    py1   <= pixel_y;
    nx2   <= $signed({2'b00, res}) - $signed({2'b00, px1, 1'b0}) - 15'sd1;
    ny2   <= $signed({2'b00, res}) - $signed({2'b00, py1, 1'b0}) - 15'sd1;
    mx3   <= mx_c;
    my3   <= my_c;
    negx3 <= nx2[14];
    negy3 <= ny2[14];
    sqx3  <= 28'(mx_c) * 28'(mx_c);
    sqy3  <= 28'(my_c) * 28'(my_c);
    numx4 <= {mx3, 15'b0} + 29'(res);
    numy4 <= {my3, 15'b0} + 29'(res);
    dz4   <= in4_c ? res_sq - r2[SQ_W-1:0] : '0;
    in4   <= in4_c;
    negx4 <= negx3;
    negy4 <= negy3;
  end
  assign side4 = '{valid: v4, in_disc: in4, neg_x: negx4, neg_y: negy4};

  // Dividers for the plane coordinates and for d / res^2, then the root
  logic [14:0] qx, qy;
  logic [30:0] qz;
  logic [15:0] tz;

  fre_div #(.NW(29), .DW(RES_W + 1), .QW(15)) u_div_x (
    .clk(clk), .num(numx4), .den({res, 1'b0}), .quo(qx)
  );
  fre_div #(.NW(29), .DW(RES_W + 1), .QW(15)) u_div_y (
    .clk(clk), .num(numy4), .den({res, 1'b0}), .quo(qy)
  );
  fre_div #(.NW(SQ_W + 30), .DW(SQ_W), .QW(31)) u_div_z (
    .clk(clk), .num({dz4, 30'b0}), .den(res_sq), .quo(qz)
  );
  fre_sqrt #(.AW(31)) u_sqrt (
    .clk(clk), .arg(qz), .root(tz)
  );

  // Delay sideband and plane coordinates to meet the root
  side_t       side_d [0:ZD_LAT-1];
  logic [14:0] qx_d   [0:ZD_LAT-XD_LAT-1];
  logic [14:0] qy_d   [0:ZD_LAT-XD_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ZD_LAT; k++) side_d[k] <= '0;
    end else begin
      side_d[0] <= side4;
      for (int k = 1; k < ZD_LAT; k++) side_d[k] <= side_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    qx_d[0] <= qx;
    qy_d[0] <= qy;
    for (int k = 1; k < ZD_LAT - XD_LAT; k++) begin
      qx_d[k] <= qx_d[k-1];
      qy_d[k] <= qy_d[k-1];
    end
  end

  // Rotation stages
  side_t                   side_r1, side_r2, side_r3;
  logic signed [15:0]      sx_c, sy_c, sz_c;
  logic signed [31:0]      pc_x, ps_z, ps_x, pc_z;
  logic signed [15:0]      y1_r1, y1_r2;
  logic signed [32:0]      sum_x2, sum_z2;
  logic signed [18:0]      x2, z2, z2_r3;
  logic signed [34:0]      hc_x, hs_y, hc_y, hs_x;
  logic signed [35:0]      sum_x3, sum_y3;

  always_comb begin
    sx_c = side_d[ZD_LAT-1].neg_x ? -$signed({1'b0, qx_d[ZD_LAT-XD_LAT-1]})
                                  :  $signed({1'b0, qx_d[ZD_LAT-XD_LAT-1]});
    sy_c = side_d[ZD_LAT-1].neg_y ? -$signed({1'b0, qy_d[ZD_LAT-XD_LAT-1]})
                                  :  $signed({1'b0, qy_d[ZD_LAT-XD_LAT-1]});
    sz_c = $signed(16'((17'(tz) + 17'd1) >> 1));
    sum_x2 = 33'(pc_x) - 33'(ps_z) + 33'sd8192;
    sum_z2 = 33'(ps_x) + 33'(pc_z) + 33'sd8192;
    sum_x3 = 36'(hc_x) + 36'(hs_y) + 36'sd8192;
    sum_y3 = 36'(hc_y) - 36'(hs_x) + 36'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_r1 <= '0;
      side_r2 <= '0;
      side_r3 <= '0;
      done    <= 1'b0;
    end else begin
      side_r1 <= side_d[ZD_LAT-1];
      side_r2 <= side_r1;
      side_r3 <= side_r2;
      done    <= side_r3.valid;
    end
  end

  always_ff @(posedge clk) begin
    // Pitch products, swapped frame: x1 = sy, y1 = -sx
    pc_x  <= 32'(cos_p) * 32'(sy_c);
    ps_z  <= 32'(sin_p) * 32'(sz_c);
    ps_x  <= 32'(sin_p) * 32'(sy_c);
    pc_z  <= 32'(cos_p) * 32'(sz_c);
    y1_r1 <= -sx_c;
    // Round pitch sums
    x2    <= sum_x2[32:14];
    z2    <= sum_z2[32:14];
    y1_r2 <= y1_r1;
    // Heading products
    hc_x  <= 35'(cos_h) * 35'(x2);
    hs_y  <= 35'(sin_h) * 35'(y1_r2);
    hc_y  <= 35'(cos_h) * 35'(y1_r2);
    hs_x  <= 35'(sin_h) * 35'(x2);
    z2_r3 <= z2;
    // Round, saturate, drop the vector outside the disc
    inside_res <= side_r3.in_disc;
    dir_x <= side_r3.in_disc ? q14_sat(sum_x3[35:14]) : '0;
    dir_y <= side_r3.in_disc ? q14_sat(sum_y3[35:14]) : '0;
    dir_z <= side_r3.in_disc ? q14_sat(22'(z2_r3)) : '0;
  end

  // Checks
  a_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching start");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && !inside_res |-> dir_x == 0 && dir_y == 0 && dir_z == 0)
    else $error("outside pixel gave a non-zero vector");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384 &&
             dir_y <= 16'sd16384 && dir_y >= -16'sd16384 &&
             dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
    else $error("direction component out of range");

endmodule

// ===== design/fre_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module fre_div #(
  parameter int NW = 29,
  parameter int DW = 14,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_s [0:QW-1];
  logic [DW-1:0] den_s [0:QW-1];
  logic [QW-1:0] quo_s [0:QW];

  assign rem_s[0] = W'(num);
  assign den_s[0] = den;
  assign quo_s[0] = '0;
  assign quo      = quo_s[QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [W-1:0] sub;
    logic         take;

    // Trial subtract of the shifted divisor
    always_comb begin
      sub  = W'(den_s[s]) << B;
      take = rem_s[s] >= sub;
    end

    // Advance quotient, remainder and divisor
    always_ff @(posedge clk) begin
      quo_s[s+1] <= {quo_s[s][QW-2:0], take};
    end
    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_s[s+1] <= take ? rem_s[s] - sub : rem_s[s];
        den_s[s+1] <= den_s[s];
      end
    end
  end

endmodule

// ===== design/fre_sqrt.sv =====
// Pipelined integer square root: one result bit per register stage.
module fre_sqrt #(
  parameter int AW = 31
) (
  input  logic                  clk,
  input  logic [AW-1:0]         arg,
  output logic [(AW+1)/2-1:0]   root
);

  localparam int N = (AW + 1) / 2;
  localparam int W = AW + 1;

  logic [W-1:0] rad_s [0:N-1];
  logic [W-1:0] res_s [0:N];

  assign rad_s[0] = W'(arg);
  assign res_s[0] = '0;
  assign root     = res_s[N][N-1:0];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
    logic [W-1:0] trial;
    logic         take;

    // Test the next root bit
    always_comb begin
      trial = res_s[s] + BIT;
      take  = rad_s[s] >= trial;
    end

    always_ff @(posedge clk) begin
      res_s[s+1] <= take ? (res_s[s] >> 1) + BIT : res_s[s] >> 1;
    end
    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rad_s[s+1] <= take ? rad_s[s] - trial : rad_s[s];
      end
    end
  end

endmodule

// ===== sim/fisheye_ray_direction_tb.sv =====
// Self-checking testbench for the fisheye ray direction pipeline.
module fisheye_ray_direction_tb;
  import fre_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } pixel_t;

  typedef struct {
    logic signed [Q14_W-1:0] dx;
    logic signed [Q14_W-1:0] dy;
    logic signed [Q14_W-1:0] dz;
    logic                    in_disc;
  } ray_t;

  localparam int LATENCY = 55;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] pixel_x = '0;
  logic [PIX_W-1:0] pixel_y = '0;
  logic done;
  logic signed [Q14_W-1:0] dir_x, dir_y, dir_z;
  logic inside_res;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [Q14_W-1:0] wr_data = '0;

  // Predictor copy of the registers
  longint m_res, m_ch, m_sh, m_cp, m_sp;

  pixel_t pixel_q[$];
  ray_t   ray_q[$];
  int     errors = 0;
  int     wait_left = 0;
  int     idle_cycles = 0;
  bit     drive_en = 1'b0;

  fisheye_ray_direction dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .inside_res(inside_res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint isqrt(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint coord_q14(longint n, longint res);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (2 * m * Q14_ONE + res) / (2 * res);
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint rnd14(longint v);
    longint w;
    w = v + 8192;
    if (w >= 0) return w >>> 14;
    return -((-w + 16383) >>> 14);
  endfunction

  function automatic logic signed [Q14_W-1:0] clamp14(longint v);
    if (v > Q14_ONE) return Q14_W'(Q14_ONE);
    if (v < -Q14_ONE) return Q14_W'(-Q14_ONE);
    return v[Q14_W-1:0];
  endfunction

  // Compute the expected ray for one pixel
  function automatic ray_t predict_ray(pixel_t p);
    ray_t r;
    longint res, nx, ny, r2, d, sx, sy, sz, x1, y1, x2, z2, x3, y3;
    res = m_res;
    if (res < 1) res = 1;
    if (res > 4096) res = 4096;
    nx = res - 2 * longint'(p.px) - 1;
    ny = res - 2 * longint'(p.py) - 1;
    r2 = nx * nx + ny * ny;
    r = '{dx: 0, dy: 0, dz: 0, in_disc: 1'b0};
    if (r2 > res * res) return r;
    d = res * res - r2;
    sx = coord_q14(nx, res);
    sy = coord_q14(ny, res);
    sz = (isqrt((d << 30) / (res * res)) + 1) >>> 1;
    x1 = sy;
    y1 = -sx;
    x2 = rnd14(m_cp * x1 - m_sp * sz);
    z2 = rnd14(m_sp * x1 + m_cp * sz);
    x3 = rnd14(m_ch * x2 + m_sh * y1);
    y3 = rnd14(m_ch * y1 - m_sh * x2);
    r.dx = clamp14(x3);
    r.dy = clamp14(y3);
    r.dz = clamp14(z2);
    r.in_disc = 1'b1;
    return r;
  endfunction

  // Drive pixels from the pending queue with random gaps
  always @(posedge clk) begin
    if (rst || !drive_en) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      ray_q.push_back(predict_ray('{px: pixel_x, py: pixel_y}));
      void'(pixel_q.pop_front());
      wait_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (pixel_q.size() > 0 && wait_left == 0) begin
        pixel_x <= pixel_q[0].px;
        pixel_y <= pixel_q[0].py;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pixel_q.size() > 0) begin
      if (wait_left > 0) begin
        wait_left--;
      end else begin
        start <= 1'b1;
        pixel_x <= pixel_q[0].px;
        pixel_y <= pixel_q[0].py;
      end
    end
  end

  // Check each strobed ray against the oldest prediction
  always @(posedge clk) begin
    ray_t e;
    if (!rst && done) begin
      if (ray_q.size() == 0) begin
        $display("%0t: unexpected ray x=%0d y=%0d z=%0d in=%0b", $time,
                 dir_x, dir_y, dir_z, inside_res);
        errors++;
      end else begin
        e = ray_q.pop_front();
        if (dir_x !== e.dx) begin
          $display("%0t: dir_x expected %0d actual %0d", $time, e.dx, dir_x);
          errors++;
        end
        if (dir_y !== e.dy) begin
          $display("%0t: dir_y expected %0d actual %0d", $time, e.dy, dir_y);
          errors++;
        end
        if (dir_z !== e.dz) begin
          $display("%0t: dir_z expected %0d actual %0d", $time, e.dz, dir_z);
          errors++;
        end
        if (inside_res !== e.in_disc) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, e.in_disc,
                   inside_res);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [Q14_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_RESOLUTION:  m_res = longint'(val[RES_W-1:0]);
      REG_COS_HEADING: m_ch = longint'(signed'(val));
      REG_SIN_HEADING: m_sh = longint'(signed'(val));
      REG_COS_PITCH:   m_cp = longint'(signed'(val));
      REG_SIN_PITCH:   m_sp = longint'(signed'(val));
      default: ;
    endcase
  endtask

  // Hold until the pipeline has drained
  task automatic drain();
    while (pixel_q.size() > 0 || start || ray_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic add_pixel(int x, int y);
    pixel_q.push_back('{px: x[PIX_W-1:0], py: y[PIX_W-1:0]});
  endtask

  function automatic logic [Q14_W-1:0] rand_trig();
    case ($urandom_range(0, 5))
      0: return 16'd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return Q14_W'($urandom());
      default: return Q14_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [Q14_W-1:0] rand_res();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd4096;
      3: return Q14_W'($urandom_range(4097, 8191));
      4: return 16'd0;
      default: return Q14_W'($urandom_range(3, 300));
    endcase
  endfunction

  initial begin
    int res;
    m_res = 100; m_ch = Q14_ONE; m_sh = 0; m_cp = Q14_ONE; m_sp = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drive_en = 1'b1;

    // Directed: corners, centre, edge and out-of-range pixels at reset values
    add_pixel(0, 0);
    add_pixel(99, 99);
    add_pixel(49, 49);
    add_pixel(50, 50);
    add_pixel(0, 49);
    add_pixel(49, 0);
    add_pixel(99, 50);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(150, 49);
    drain();

    // Directed: extreme trig and resolution settings
    write_reg(REG_RESOLUTION, 16'd1);
    write_reg(REG_COS_HEADING, -16'sd16384);
    write_reg(REG_SIN_HEADING, 16'd16384);
    write_reg(REG_COS_PITCH, 16'h7fff);
    write_reg(REG_SIN_PITCH, 16'h8000);
    add_pixel(0, 0);
    add_pixel(1, 0);
    drain();
    write_reg(REG_RESOLUTION, 16'd4096);
    add_pixel(0, 2048);
    add_pixel(2048, 0);
    add_pixel(2047, 2047);
    add_pixel(4095, 2048);
    drain();
    write_reg(REG_RESOLUTION, 16'd0);
    add_pixel(0, 0);
    drain();
    write_reg(REG_RESOLUTION, 16'h1fff);
    add_pixel(2048, 2048);
    add_pixel(4095, 4095);
    drain();

    // Random phases with fresh register settings
    for (int ph = 0; ph < 27; ph++) begin
      write_reg(REG_RESOLUTION, rand_res());
      write_reg(REG_COS_HEADING, rand_trig());
      write_reg(REG_SIN_HEADING, rand_trig());
      write_reg(REG_COS_PITCH, rand_trig());
      write_reg(REG_SIN_PITCH, rand_trig());
      res = (m_res < 1) ? 1 : (m_res > 4096 ? 4096 : int'(m_res));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0) add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        else add_pixel($urandom_range(0, res - 1), $urandom_range(0, res - 1));
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
